// ===== sv/kvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  // Event codes on the input channel
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_DIAL   = 2'd1,
    CMD_BUTTON = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_MIN_TICKS   = 3'd0,
    CFG_MAX_TICKS   = 3'd1,
    CFG_STEP        = 3'd2,
    CFG_START       = 3'd3,
    CFG_TOGGLE_MODE = 3'd4
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LED_W      = 21;

  localparam logic signed [31:0] STEP_RESET   = 32'sd65536;
  localparam logic               TOGGLE_RESET = 1'b0;

  // LED pulse word layout
  localparam logic [7:0] LED_BRIGHT_IDLE = 8'd128;
  localparam logic [8:0] LED_SPEED       = 9'd255;
  localparam int unsigned LED_ASLEEP_BIT = 19;

  typedef struct packed {
    logic signed [31:0] min_ticks;
    logic signed [31:0] max_ticks;
    logic signed [31:0] step_per_tick;
    logic signed [31:0] start_value;
    logic               toggle_mode;
  } cfg_t;

  // Item leaving the state stage
  typedef struct packed {
    logic signed [31:0] offset;
    logic               sample_valid;
    logic               button_state;
    logic               led_write;
  } stage_t;

  function automatic logic [LED_W-1:0] led_pulse_word(input logic button);
    logic [LED_W-1:0] w;
    w = '0;
    w[7:0] = button ? 8'd0 : LED_BRIGHT_IDLE;
    w[16:8] = LED_SPEED;
    w[LED_ASLEEP_BIT] = 1'b1;
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kvt_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface kvt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] event_value;

  modport source (output valid, output command, output event_value, input ready);
  modport sink (input valid, input command, input event_value, output ready);
endinterface

`default_nettype wire

// ===== sv/kvt_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface kvt_out_if;
  logic               valid;
  logic               ready;
  logic               sample_valid;
  logic signed [31:0] scaled_value;
  logic               button_state;
  logic               led_write;
  logic [20:0]        led_word;

  modport source (
    output valid, output sample_valid, output scaled_value, output button_state,
    output led_write, output led_word, input ready
  );
  modport sink (
    input valid, input sample_valid, input scaled_value, input button_state,
    input led_write, input led_word, output ready
  );
endinterface

`default_nettype wire

// ===== sv/kvt_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kvt_state import kvt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               take,
  input  wire logic [1:0]         command,
  input  wire logic signed [15:0] event_value,
  output stage_t                  stage
);

  logic signed [31:0] tick_offset, tick_offset_next;
  logic               button_level, button_level_next;
  logic [1:0]         samples_since_press, samples_since_press_next;
  logic               quick_click_pending, quick_click_pending_next;

  logic               st_sample, st_sample_next;
  logic               st_button, st_button_next;
  logic               st_led, st_led_next;

  logic signed [32:0] dial_sum;
  logic signed [32:0] lo_ext;
  logic signed [32:0] hi_ext;
  logic signed [32:0] clamped;
  logic               pressed;

  always_comb begin
    dial_sum = {tick_offset[31], tick_offset} + {{17{event_value[15]}}, event_value};
    lo_ext   = {cfg.min_ticks[31], cfg.min_ticks};
    hi_ext   = {cfg.max_ticks[31], cfg.max_ticks};
    // low bound first, then high: inverted limits settle on max_ticks
    clamped  = dial_sum;
    if (clamped < lo_ext) begin
      clamped = lo_ext;
    end
    if (clamped > hi_ext) begin
      clamped = hi_ext;
    end
    pressed = (event_value != 16'sd0);

    tick_offset_next         = tick_offset;
    button_level_next        = button_level;
    samples_since_press_next = samples_since_press;
    quick_click_pending_next = quick_click_pending;
    st_sample_next           = 1'b0;
    st_led_next              = 1'b0;
    st_button_next           = button_level;

    unique case (cmd_t'(command))
      CMD_SAMPLE: begin
        st_sample_next = 1'b1;
        if (samples_since_press != 2'd3) begin
          samples_since_press_next = samples_since_press + 2'd1;
        end
        // pending quick click: report the held state, then clear
        if (quick_click_pending) begin
          button_level_next        = 1'b0;
          quick_click_pending_next = 1'b0;
        end
      end
      CMD_DIAL: begin
        tick_offset_next = clamped[31:0];
      end
      CMD_BUTTON: begin
        if (cfg.toggle_mode) begin
          if (pressed && samples_since_press == 2'd3) begin
            button_level_next = ~button_level;
          end
        end else if (samples_since_press == 2'd0) begin
          quick_click_pending_next = 1'b1;
        end else begin
          button_level_next = pressed;
        end
        tick_offset_next         = '0;
        samples_since_press_next = 2'd0;
        st_led_next              = 1'b1;
        st_button_next           = button_level_next;
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_offset         <= '0;
      button_level        <= TOGGLE_RESET;
      samples_since_press <= 2'd0;
      quick_click_pending <= 1'b0;
    end else if (take) begin
      tick_offset         <= tick_offset_next;
      button_level        <= button_level_next;
      samples_since_press <= samples_since_press_next;
      quick_click_pending <= quick_click_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      st_sample <= st_sample_next;
      st_button <= st_button_next;
      st_led    <= st_led_next;
    end
  end

  // tick_offset only moves on a transfer, together with the flags
  assign stage.offset       = tick_offset;
  assign stage.sample_valid = st_sample;
  assign stage.button_state = st_button;
  assign stage.led_write    = st_led;

  a_click_only_before_sample: assert property (@(posedge clk) disable iff (rst)
    quick_click_pending |-> (samples_since_press == 2'd0))
    else $error("quick click pending with samples counted");

  a_button_zeroes_offset: assert property (@(posedge clk) disable iff (rst)
    (take && command == CMD_BUTTON) |=> (tick_offset == 32'sd0))
    else $error("button event left a tick offset");

endmodule

`default_nettype wire

// ===== sv/kvt_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kvt_scale import kvt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire stage_t  s1,
  input  wire logic    s1_valid,
  output logic         s1_take,
  kvt_out_if.source    results
);

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  logic               v2, v3;
  logic               ready2, ready3;
  logic signed [63:0] mult;
  logic signed [63:0] product;
  logic               p_sample, p_button, p_led;
  logic signed [63:0] sum;
  logic signed [31:0] sat;

  logic               r_sample, r_button, r_led;
  logic signed [31:0] r_value;
  logic [LED_W-1:0]   r_word;

  assign ready3  = !v3 || results.ready;
  assign ready2  = !v2 || ready3;
  assign s1_take = ready2;

  assign mult = $signed(s1.offset) * $signed(cfg.step_per_tick);

  always_comb begin
    sum = product + {{32{cfg.start_value[31]}}, cfg.start_value};
    if (sum > SAT_MAX) begin
      sat = 32'sh7FFFFFFF;
    end else if (sum < SAT_MIN) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready2) begin
        v2 <= s1_valid;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      product  <= mult;
      p_sample <= s1.sample_valid;
      p_button <= s1.button_state;
      p_led    <= s1.led_write;
    end
    if (ready3 && v2) begin
      r_value  <= sat;
      r_sample <= p_sample;
      r_button <= p_button;
      r_led    <= p_led;
      r_word   <= p_led ? led_pulse_word(p_button) : '0;
    end
  end

  assign results.valid        = v3;
  assign results.sample_valid = r_sample;
  assign results.scaled_value = r_value;
  assign results.button_state = r_button;
  assign results.led_write    = r_led;
  assign results.led_word     = r_word;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    v3 |-> !(r_sample && r_led))
    else $error("result flagged both sample and LED write");

  a_word_only_with_write: assert property (@(posedge clk) disable iff (rst)
    (v3 && !r_led) |-> (r_word == '0))
    else $error("LED word without LED write");

endmodule

`default_nettype wire

// ===== sv/rotary_knob_value_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Fields                                             Transfer
// events    in   command[1:0], event_value[15:0] signed             valid & ready
// results   out  sample_valid, scaled_value[31:0] signed,           valid & ready
//                button_state, led_write, led_word[20:0]
// cfg       in   cfg_index[2:0], cfg_data[31:0]                     cfg_we
//
// One item per cycle sustained while results is taken; exactly one result per item.
// Each item passes the state stage, then the 32x32 product register, then
// add/saturate into the result register, from which its result is offered.
// Stalls ripple back stage by stage; events.ready drops only when all three
// stages are full and results is not taken.
// Reset (rst, synchronous) empties the pipe and restores register defaults.

module rotary_knob_value_tracker import kvt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  kvt_in_if.sink                     events,
  kvt_out_if.source                  results
);

  cfg_t   cfg;
  stage_t s1;
  logic   v1;
  logic   s1_take;
  logic   take;

  // Configuration registers; software must write them only while idle (the block does not enforce it)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_ticks     <= '0;
      cfg.max_ticks     <= '0;
      cfg.step_per_tick <= STEP_RESET;
      cfg.start_value   <= '0;
      cfg.toggle_mode   <= TOGGLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_TICKS:   cfg.min_ticks     <= cfg_data;
        CFG_MAX_TICKS:   cfg.max_ticks     <= cfg_data;
        CFG_STEP:        cfg.step_per_tick <= cfg_data;
        CFG_START:       cfg.start_value   <= cfg_data;
        CFG_TOGGLE_MODE: cfg.toggle_mode   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // State stage takes a transfer when it is empty or its item moves on
  assign events.ready = !v1 || s1_take;
  assign take         = events.valid && events.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (take) begin
      v1 <= 1'b1;
    end else if (s1_take) begin
      v1 <= 1'b0;
    end
  end

  kvt_state u_state (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .command     (events.command),
    .event_value (events.event_value),
    .stage       (s1)
  );

  kvt_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1       (s1),
    .s1_valid (v1),
    .s1_take  (s1_take),
    .results  (results)
  );

  a_take_fills_stage: assert property (@(posedge clk) disable iff (rst)
    take |=> v1)
    else $error("transfer did not fill the state stage");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !results.valid)
    else $error("result offered straight after reset");

endmodule

`default_nettype wire

// ===== verif/knob_result_check.sv =====
`timescale 1ns / 1ps

module knob_result_check import kvt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  kvt_in_if                     evt,
  kvt_out_if                    res,
  output int                    fail_cnt,
  output int                    waiting_cnt,
  output int                    checked_cnt,
  output int                    sample_cnt,
  output int                    press_cnt,
  output int                    in_stall_cnt
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct {
    logic               sample_valid;
    logic signed [31:0] scaled_value;
    logic               button_state;
    logic               led_write;
    logic [LED_W-1:0]   led_word;
  } readout_t;

  readout_t pending_readouts[$];
  readout_t want;

  // register copies
  logic signed [31:0] lim_lo, lim_hi, step_q, base_q;
  logic               toggle_on;

  // knob state
  logic signed [31:0] offs;
  logic               btn;
  logic [1:0]         samples_seen;
  logic               click_pending;

  function automatic readout_t step_knob(input cmd_t cmd, input logic signed [15:0] ev);
    readout_t r;
    longint   x;
    logic     pressed;
    r.sample_valid = 1'b0;
    r.led_write    = 1'b0;
    r.led_word     = '0;
    case (cmd)
      CMD_DIAL: begin
        // wide sum, then clamp low first so inverted limits end on the high one
        x = longint'(offs) + longint'(ev);
        if (x < longint'(lim_lo)) x = longint'(lim_lo);
        if (x > longint'(lim_hi)) x = longint'(lim_hi);
        offs = 32'(x);
      end
      CMD_BUTTON: begin
        pressed = (ev != 16'sd0);
        if (toggle_on) begin
          if (pressed && samples_seen > 2'd2) btn = ~btn;
        end else if (samples_seen == 2'd0) begin
          click_pending = 1'b1;
        end else begin
          btn = pressed;
        end
        offs            = '0;
        samples_seen    = '0;
        r.led_write     = 1'b1;
        r.led_word[7:0] = btn ? 8'd0 : LED_BRIGHT_IDLE;
        r.led_word[16:8] = LED_SPEED;
        r.led_word[LED_ASLEEP_BIT] = 1'b1;
      end
      default: ;
    endcase
    x = longint'(offs) * longint'(step_q) + longint'(base_q);
    if (x > Q_MAX) x = Q_MAX;
    if (x < Q_MIN) x = Q_MIN;
    r.scaled_value = 32'(x);
    r.button_state = btn;
    if (cmd == CMD_SAMPLE) begin
      r.sample_valid = 1'b1;
      if (samples_seen != 2'd3) samples_seen = samples_seen + 2'd1;
      if (click_pending) begin
        btn           = 1'b0;
        click_pending = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic field_check(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] got_v);
    if (got_v !== exp_v) begin
      fail_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lim_lo        = '0;
      lim_hi        = '0;
      step_q        = STEP_RESET;
      base_q        = '0;
      toggle_on     = TOGGLE_RESET;
      offs          = '0;
      btn           = TOGGLE_RESET;
      samples_seen  = '0;
      click_pending = 1'b0;
      pending_readouts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MIN_TICKS:   lim_lo    = cfg_data;
          CFG_MAX_TICKS:   lim_hi    = cfg_data;
          CFG_STEP:        step_q    = cfg_data;
          CFG_START:       base_q    = cfg_data;
          CFG_TOGGLE_MODE: toggle_on = cfg_data[0];
          default: ;
        endcase
      end
      if (evt.valid && !evt.ready) in_stall_cnt++;
      // results first: a transfer out can never belong to an item taken this edge
      if (res.valid && res.ready) begin
        checked_cnt++;
        if (pending_readouts.size() == 0) begin
          fail_cnt++;
          $display("%0t ns: result transfer with nothing expected", $time);
        end else begin
          want = pending_readouts.pop_front();
          field_check("sample_valid", want.sample_valid, res.sample_valid);
          field_check("scaled_value", want.scaled_value, res.scaled_value);
          field_check("button_state", want.button_state, res.button_state);
          field_check("led_write", want.led_write, res.led_write);
          field_check("led_word", want.led_word, res.led_word);
        end
      end
      if (evt.valid && evt.ready) begin
        if (cmd_t'(evt.command) == CMD_SAMPLE) sample_cnt++;
        if (cmd_t'(evt.command) == CMD_BUTTON) press_cnt++;
        pending_readouts.push_back(step_knob(cmd_t'(evt.command), evt.event_value));
      end
    end
    waiting_cnt = pending_readouts.size();
  end

endmodule

// ===== verif/tb_rotary_knob_value_tracker.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the knob tracker. All prediction and comparison
// lives in knob_result_check, which sits beside the block on the same wires.
module tb_rotary_knob_value_tracker import kvt_pkg::*;;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;     // margin after the last result is back
  localparam int PHASE_ITEMS  = 90;
  localparam int PHASES       = 8;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kvt_in_if  knob_in ();
  kvt_out_if knob_out ();

  int fail_cnt, waiting_cnt, checked_cnt, sample_cnt, press_cnt, in_stall_cnt;

  // knobs for the two idling processes
  bit tx_idle_on;
  bit rx_idle_on;
  int hold_req;        // long receiver hold-off, picked up by the receiver itself
  int items_sent;
  int settings_cnt;
  int cycle_cnt;

  rotary_knob_value_tracker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .events    (knob_in),
    .results   (knob_out)
  );

  knob_result_check u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .evt          (knob_in),
    .res          (knob_out),
    .fail_cnt     (fail_cnt),
    .waiting_cnt  (waiting_cnt),
    .checked_cnt  (checked_cnt),
    .sample_cnt   (sample_cnt),
    .press_cnt    (press_cnt),
    .in_stall_cnt (in_stall_cnt)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends here rather than running forever
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_cnt, waiting_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until the transfer.
  // Valid is only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_event(input cmd_t cmd, input logic [15:0] val);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      @(negedge clk);
      knob_in.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    knob_in.valid       <= 1'b1;
    knob_in.command     <= cmd;
    knob_in.event_value <= val;
    do @(posedge clk); while (!knob_in.ready);
    items_sent++;
  endtask

  // Stop offering and let every outstanding result come back, plus a margin
  task automatic drain();
    @(negedge clk);
    knob_in.valid <= 1'b0;
    wait (waiting_cnt == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A fresh set of registers; drains the block first so it is idle for the writes
  task automatic new_settings();
    logic signed [31:0] lo, hi, step, base;
    case ($urandom_range(0, 4))
      0: begin
        lo = 32'sh80000000;
        hi = 32'sh7FFFFFFF;
      end
      1: begin
        lo = -int'($urandom_range(0, 300));
        hi = int'($urandom_range(0, 300));
      end
      2: begin        // inverted limits: a turn always lands the offset on max_ticks
        lo = int'($urandom_range(1, 500));
        hi = -int'($urandom_range(0, 500));
      end
      3: begin
        lo = $urandom;
        hi = $urandom;
      end
      default: begin
        lo = -int'($urandom_range(0, 100000));
        hi = int'($urandom_range(0, 100000));
      end
    endcase
    case ($urandom_range(0, 4))
      0: step = $urandom;
      1: step = int'($urandom_range(0, 200000)) - 100000;
      2: step = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      3: step = (int'($urandom_range(0, 8)) - 4) <<< 16;
      default: step = 32'sd0;
    endcase
    base = $urandom_range(0, 1) ? $urandom : 32'(int'($urandom_range(0, 131072)) - 65536);
    drain();
    write_reg(CFG_MIN_TICKS, lo);
    write_reg(CFG_MAX_TICKS, hi);
    write_reg(CFG_STEP, step);
    write_reg(CFG_START, base);
    write_reg(CFG_TOGGLE_MODE, 32'($urandom_range(0, 1)));
    settings_cnt++;
  endtask

  task automatic random_event();
    int          pick;
    logic [15:0] val;
    pick = $urandom_range(0, 99);
    val  = 16'($urandom);
    if (pick < 35) begin
      send_event(CMD_SAMPLE, val);
    end else if (pick < 70) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: val = 16'(int'($urandom_range(0, 400)) - 200);
        6: val = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        default: ;
      endcase
      send_event(CMD_DIAL, val);
    end else if (pick < 95) begin
      if ($urandom_range(0, 4) != 0) val = 16'($urandom_range(0, 1));
      send_event(CMD_BUTTON, val);
    end else begin
      send_event(CMD_NONE, val);
    end
  endtask

  // Press, a few ticks or turns, release: the shape a real knob produces.
  // Zero ticks before or between gives quick clicks; three or more arm a toggle.
  task automatic click_sequence();
    int n_before, n_held;
    n_before = $urandom_range(0, 4);
    n_held   = $urandom_range(0, 3);
    repeat (n_before) send_event(CMD_SAMPLE, 16'($urandom));
    send_event(CMD_BUTTON, 16'h0001);
    repeat (n_held)
      send_event($urandom_range(0, 1) ? CMD_SAMPLE : CMD_DIAL,
                 16'(int'($urandom_range(0, 40)) - 20));
    send_event(CMD_BUTTON, 16'h0000);
  endtask

  // Receiver: random stall before each result, or a long hold-off on request
  initial begin
    int stall;
    knob_out.ready = 1'b0;
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        @(negedge clk);
        knob_out.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      knob_out.ready <= 1'b1;
      do @(posedge clk); while (!(knob_out.valid && knob_out.ready));
    end
  end

  initial begin
    int phase_items;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    knob_in.valid       = 1'b0;
    knob_in.command     = CMD_SAMPLE;
    knob_in.event_value = '0;
    tx_idle_on          = 1'b1;
    rx_idle_on          = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset settings (follow mode, limits 0..0):
    // press straight after reset is a quick click, then a normal press,
    // a release with no tick in between (quick click clears on the next tick),
    // a turn pinned at zero and an ignored command.
    send_event(CMD_BUTTON, 16'h0001);
    send_event(CMD_SAMPLE, 16'h0000);
    send_event(CMD_SAMPLE, 16'hFFFF);
    send_event(CMD_BUTTON, 16'h0001);
    send_event(CMD_BUTTON, 16'h0000);
    send_event(CMD_SAMPLE, 16'h0000);
    send_event(CMD_SAMPLE, 16'h0000);
    send_event(CMD_DIAL, 16'h0005);
    send_event(CMD_NONE, 16'hFFFF);

    // Both limits at the top, largest step, lowest start: value saturates high
    drain();
    write_reg(CFG_MIN_TICKS, 32'h7FFFFFFF);
    write_reg(CFG_MAX_TICKS, 32'h7FFFFFFF);
    write_reg(CFG_STEP, 32'h7FFFFFFF);
    write_reg(CFG_START, 32'h80000000);
    write_reg(CFG_TOGGLE_MODE, 32'd1);
    send_event(CMD_DIAL, 16'h8000);
    send_event(CMD_SAMPLE, 16'h0000);

    // Open the lower limit with the offset parked at the top: a further
    // turn up only fits if the sum is formed wide before the clamp.
    // Then the tick counter saturates and a toggle press is armed.
    drain();
    write_reg(CFG_MIN_TICKS, 32'h80000000);
    send_event(CMD_DIAL, 16'h7FFF);
    send_event(CMD_SAMPLE, 16'h0000);
    send_event(CMD_DIAL, 16'h8000);
    send_event(CMD_SAMPLE, 16'h0000);
    send_event(CMD_SAMPLE, 16'h0000);
    send_event(CMD_BUTTON, 16'h8000);   // toggles
    send_event(CMD_BUTTON, 16'h0001);   // too soon, no toggle
    send_event(CMD_BUTTON, 16'h0000);   // release ignored in toggle mode

    // Inverted limits, most negative step, back to follow mode
    drain();
    write_reg(CFG_MIN_TICKS, 32'd1000);
    write_reg(CFG_MAX_TICKS, 32'hFFFFFC18);
    write_reg(CFG_STEP, 32'h80000000);
    write_reg(CFG_START, 32'h7FFFFFFF);
    write_reg(CFG_TOGGLE_MODE, 32'd0);
    send_event(CMD_DIAL, 16'h0000);
    send_event(CMD_SAMPLE, 16'h0000);
    send_event(CMD_BUTTON, 16'h0001);
    settings_cnt = 4;

    // Random phases, each with its own settings and idling pattern
    for (int phase = 0; phase < PHASES; phase++) begin
      new_settings();
      tx_idle_on  = (phase % 3 != 0) && (phase != 4);
      rx_idle_on  = (phase % 3 != 0);
      phase_items = 0;
      if (phase == 2) begin
        // receiver sits on its hands while items keep coming back to back,
        // so the pipe fills and the input stalls
        tx_idle_on = 1'b0;
        hold_req   = 80;
        repeat (30) random_event();
        phase_items = 30;
        tx_idle_on  = 1'b1;
      end
      while (phase_items < PHASE_ITEMS) begin
        if (phase == 5 && phase_items >= PHASE_ITEMS / 2 && phase_items < PHASE_ITEMS / 2 + 5)
          drain();       // sender pause until everything is back
        if ($urandom_range(0, 3) == 0) begin
          click_sequence();
          phase_items += 6;
        end else begin
          random_event();
          phase_items++;
        end
      end
    end

    drain();
    $display("Run covered %0d transfers in and %0d results over %0d register settings",
             items_sent, checked_cnt, settings_cnt);
    $display("  incl. %0d sample ticks, %0d button events, %0d input stall cycles",
             sample_cnt, press_cnt, in_stall_cnt);
    if (fail_cnt == 0 && waiting_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kvt_pkg.sv
sv/kvt_in_if.sv
sv/kvt_out_if.sv
sv/kvt_state.sv
sv/kvt_scale.sv
sv/rotary_knob_value_tracker.sv
verif/knob_result_check.sv
verif/tb_rotary_knob_value_tracker.sv
